### src/lca_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the cellular automaton step block.
// Depends on nothing; used by the channel interfaces and the top level.
package lca_pkg;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 12;
	localparam int SIDE_CFG_W = 7;

	// Operation codes carried on the request channel.
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam int MIN_SIDE        = 3;
	localparam int GRID_SIDE_RESET = 64;

	// Rule thresholds: a live count of three births, two keeps the cell.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [IDX_W-1:0] cell_idx_t;

endpackage

### src/lca_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces for the cellular automaton block.
// Depends on lca_pkg for field widths.
interface lca_req_if;
	logic               valid;
	logic               ready;
	lca_pkg::cmd_t      cmd;
	lca_pkg::cell_idx_t cell_index;
	logic               cell_value;

	modport source (output valid, cmd, cell_index, cell_value, input ready);
	modport sink (input valid, cmd, cell_index, cell_value, output ready);
endinterface

interface lca_rsp_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic step_done;

	modport source (output valid, cell_alive, step_done, input ready);
	modport sink (input valid, cell_alive, step_done, output ready);
endinterface

### src/life_cellular_automaton_step.sv
`timescale 1ns / 1ps
// Top level of the B3/S23 cellular automaton: grid memory, scan sequencer and rule unit.
// Depends on lca_pkg and the channel interfaces in lca_if.sv.
//
// Usage:
//   req carries one item: cmd (write cell, step, read cell), cell_index, cell_value.
//   rsp carries the result of a read (cell_alive) or of a step (step_done).
//   Writes and unused commands give no result. cfg_we/cfg_wdata set the grid side,
//   which is clamped to the range 3 to MAX_SIDE.
// Operation:
//   A write is done as it is accepted. A read result is registered in the read
//   state once the output register is free.
//   A step scans the grid once in row order through one memory read port and
//   one rule unit; its result is registered once the last cell is written. New values
//   go back into the same memory behind the scan; the rows above the current cell
//   come from two row delay lines, so no second copy of the grid is kept.
//   The block works on one item at a time; req.ready is high only while idle.
// Reset:
//   After arst_n is released a clearing pass writes every one of the
//   MAX_SIDE*MAX_SIDE cells dead before the first item is taken. Configuration
//   writes belong between items, since a step uses the side throughout its scan.
// Stalls:
//   A result waits in an output register until rsp.ready. Writes can be taken
//   meanwhile; a read or step that finishes holds until the register frees.
module life_cellular_automaton_step #(
	parameter int MAX_SIDE = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lca_pkg::SIDE_CFG_W-1:0]    cfg_wdata,
	lca_req_if.sink                           req,
	lca_rsp_if.source                         rsp
);

	localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int CNT_W   = $clog2(DEPTH + MAX_SIDE + 2);
	localparam int CMP_W   = (CNT_W > lca_pkg::IDX_W) ? CNT_W : lca_pkg::IDX_W;
	localparam int CLAMP_W = (SIDE_W > lca_pkg::SIDE_CFG_W) ? SIDE_W : lca_pkg::SIDE_CFG_W;
	localparam int RST_SIDE_I = (lca_pkg::GRID_SIDE_RESET > MAX_SIDE) ?
		MAX_SIDE : lca_pkg::GRID_SIDE_RESET;
	localparam logic [SIDE_W-1:0] RST_SIDE  = SIDE_W'(RST_SIDE_I);
	localparam logic [CNT_W-1:0]  RST_CELLS = CNT_W'(RST_SIDE_I * RST_SIDE_I);
	localparam logic [CNT_W-1:0]  LAST_CLR  = CNT_W'(DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]        state_q;
	logic [SIDE_W-1:0] side_q;
	logic [CNT_W-1:0]  cells_q;
	logic [CNT_W-1:0]  q_q;
	logic [CNT_W-1:0]  q_s1;
	logic              rd_vld_s1;
	logic              win_vld_s2;
	logic [CNT_W-1:0]  wr_idx_q;
	logic [SIDE_W-1:0] wr_row_q;
	logic [SIDE_W-1:0] wr_col_q;
	logic              in_range_q;
	logic              rdata_q;
	logic              rsp_valid_q;
	logic              rsp_alive_q;
	logic              rsp_done_q;

	logic              mem [DEPTH];
	logic              dl_a_q [MAX_SIDE];
	logic              dl_b_q [MAX_SIDE];
	logic [2:0]        win_top_q;
	logic [2:0]        win_mid_q;
	logic [2:0]        win_bot_q;

	logic              accept;
	logic              in_range;
	logic              issue;
	logic [CNT_W-1:0]  last_rd;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic              wd;
	logic [3:0]        n_live;
	logic              border;
	logic              next_cell;
	logic              out_free;
	logic              step_last;
	logic [CLAMP_W-1:0] cfg_ext;
	logic [SIDE_W-1:0] side_new;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign in_range = CMP_W'(req.cell_index) < CMP_W'(cells_q);
	assign last_rd  = cells_q + CNT_W'(side_q);
	assign issue    = (state_q == ST_STEP) && (q_q <= last_rd);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign step_last = win_vld_s2 && (wr_idx_q == cells_q - 1'b1);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_alive = rsp_alive_q;
	assign rsp.step_done  = rsp_done_q;

	// Grid side clamp, applied when the register is written.
	always_comb begin
		cfg_ext = CLAMP_W'(cfg_wdata);
		if (cfg_ext < CLAMP_W'(lca_pkg::MIN_SIDE)) begin
			side_new = SIDE_W'(lca_pkg::MIN_SIDE);
		end else if (cfg_ext > CLAMP_W'(MAX_SIDE)) begin
			side_new = SIDE_W'(MAX_SIDE);
		end else begin
			side_new = SIDE_W'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= RST_SIDE;
			cells_q <= RST_CELLS;
		end else if (cfg_we) begin
			side_q  <= side_new;
			cells_q <= CNT_W'(side_new) * CNT_W'(side_new);
		end
	end

	// Rule unit for the cell at the window center.
	always_comb begin
		n_live = 4'(win_top_q[0]) + 4'(win_top_q[1]) + 4'(win_top_q[2]) +
			4'(win_mid_q[0]) + 4'(win_mid_q[2]) +
			4'(win_bot_q[0]) + 4'(win_bot_q[1]) + 4'(win_bot_q[2]);
		border = (wr_row_q == '0) || (wr_col_q == '0) ||
			(wr_row_q == side_q - 1'b1) || (wr_col_q == side_q - 1'b1);
		if (border) begin
			next_cell = 1'b0;
		end else if (n_live == lca_pkg::BIRTH_COUNT) begin
			next_cell = 1'b1;
		end else if (n_live == lca_pkg::KEEP_COUNT) begin
			next_cell = win_mid_q[1];
		end else begin
			next_cell = 1'b0;
		end
	end

	// Memory port selection.
	always_comb begin
		we      = 1'b0;
		wa      = '0;
		wd      = 1'b0;
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(q_q);
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = ADDR_W'(q_q);
			end
			ST_IDLE: begin
				if (accept && req.cmd == lca_pkg::CMD_WRITE && in_range) begin
					we = 1'b1;
					wa = ADDR_W'(req.cell_index);
					wd = req.cell_value;
				end
				if (accept && req.cmd == lca_pkg::CMD_READ) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(req.cell_index);
				end
			end
			ST_STEP: begin
				rd_en = issue;
				if (win_vld_s2) begin
					we = 1'b1;
					wa = ADDR_W'(wr_idx_q);
					wd = next_cell;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Row delay lines: the input stage is chosen by the side, the output is stage 0,
	// so each line delays by exactly one row.
	for (genvar i = 0; i < MAX_SIDE; i++) begin : g_dl
		if (i == MAX_SIDE - 1) begin : g_end
			always_ff @(posedge clk) begin
				if (rd_vld_s1) begin
					dl_a_q[i] <= rdata_q;
					dl_b_q[i] <= dl_a_q[0];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (rd_vld_s1) begin
					dl_a_q[i] <= (SIDE_W'(i) == side_q - 1'b1) ? rdata_q : dl_a_q[i+1];
					dl_b_q[i] <= (SIDE_W'(i) == side_q - 1'b1) ? dl_a_q[0] : dl_b_q[i+1];
				end
			end
		end
	end

	// The newest column enters at bit 2.
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			win_bot_q <= {rdata_q, win_bot_q[2:1]};
			win_mid_q <= {dl_a_q[0], win_mid_q[2:1]};
			win_top_q <= {dl_b_q[0], win_top_q[2:1]};
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			q_q        <= '0;
			rd_vld_s1  <= 1'b0;
			win_vld_s2 <= 1'b0;
			wr_idx_q   <= '0;
			wr_row_q   <= '0;
			wr_col_q   <= '0;
			in_range_q <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			// The first write trails the scan by one row and one cell.
			win_vld_s2 <= (state_q == ST_STEP) && rd_vld_s1 && !step_last &&
				(q_s1 >= CNT_W'(side_q) + 1'b1);
			unique case (state_q)
				ST_CLEAR: begin
					if (q_q == LAST_CLR) begin
						q_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						q_q <= q_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						q_q        <= '0;
						wr_idx_q   <= '0;
						wr_row_q   <= '0;
						wr_col_q   <= '0;
						in_range_q <= in_range;
						if (req.cmd == lca_pkg::CMD_READ) begin
							state_q <= ST_RD;
						end else if (req.cmd == lca_pkg::CMD_STEP) begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_RD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					if (issue) begin
						q_q <= q_q + 1'b1;
					end
					if (win_vld_s2) begin
						wr_idx_q <= wr_idx_q + 1'b1;
						if (wr_col_q == side_q - 1'b1) begin
							wr_col_q <= '0;
							wr_row_q <= wr_row_q + 1'b1;
						end else begin
							wr_col_q <= wr_col_q + 1'b1;
						end
					end
					if (step_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_RD || state_q == ST_FIN) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD && out_free) begin
			rsp_alive_q <= rdata_q && in_range_q;
			rsp_done_q  <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			rsp_alive_q <= 1'b0;
			rsp_done_q  <= 1'b1;
		end
	end

	// A step never writes past the cells in use.
	a_step_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && win_vld_s2) |-> (wr_idx_q < cells_q))
		else $error("step write beyond the grid in use");

	// No item is taken while the clearing pass runs.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("item taken during clearing pass");

	// A step result only appears after the scan has finished.
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid_q) && rsp_done_q) |-> ($past(state_q) == ST_FIN))
		else $error("step result without a finished scan");

	// A result is either a read or a step, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_alive_q && rsp_done_q))
		else $error("result flags both a live cell and a step");

	// The scan write position stays at least one row and one cell behind the read position.
	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && win_vld_s2) |-> (wr_idx_q + CNT_W'(side_q) < q_q))
		else $error("write overtook the scan read");

endmodule
